// ===== sv/deadband_window_brightness_ramp_defines.svh =====
// assertion macros for the deadband window brightness ramp
// used by the top level only; expects signals named clock and reset in scope
`ifndef DEADBAND_WINDOW_BRIGHTNESS_RAMP_DEFINES_SVH
`define DEADBAND_WINDOW_BRIGHTNESS_RAMP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DBWBR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define DBWBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dbwbr_pkg.sv =====
// shared types and constants for the deadband window brightness ramp
// no dependencies
`default_nettype none

package dbwbr_pkg;

   localparam int SAMPLE_BITS_DEF = 8;
   localparam int CSR_DATA_BITS   = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int STEP_BITS       = 7;
   localparam int LEVEL_BITS      = 8;

   localparam logic [STEP_BITS-1:0] MAX_STEPS = 7'd64;
   localparam logic [STEP_BITS-1:0] MIN_STEPS = 7'd1;

   localparam logic [7:0]           DEADBAND_RST    = 8'd8;
   localparam logic [STEP_BITS-1:0] RAMP_STEPS_RST  = 7'd8;
   localparam logic [7:0]           WINDOW_LOW_RST  = 8'd16;
   localparam logic [7:0]           WINDOW_HIGH_RST = 8'd240;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEADBAND    = 2'd0,
      CSR_RAMP_STEPS  = 2'd1,
      CSR_WINDOW_LOW  = 2'd2,
      CSR_WINDOW_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_DIV   = 4'b0100,
      S_RAMP  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/dbwbr_div.sv =====
// bit-serial restoring divider: one quotient bit per cycle
// depends on dbwbr_pkg for the divisor width
`default_nettype none

module dbwbr_div
   import dbwbr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] dividend,
   input  wire logic [STEP_BITS-1:0]   divisor,
   output logic                        done,
   output logic [SAMPLE_BITS-1:0]      quotient,
   output logic [STEP_BITS-1:0]        remainder
);

   localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [STEP_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]   dvs_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS:0]     trial;
   logic [STEP_BITS:0]     diff;
   logic                   fits;

   // partial remainder stays below the divisor, so one extra bit covers the shift
   assign trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(SAMPLE_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
         rem_in = fits ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/deadband_window_brightness_ramp.sv =====
// Deadband filter and linear brightness ramp. Each sample transaction first passes a
// deadband filter; if the held value lies inside [window_low, window_high] and differs
// from the present level, the block ramps to it in ramp_steps result transactions
// (0 counts as 1, above 64 as 64), the last one flagged. A sample is filtered and
// checked, then the bit-serial divider splits the level difference by the step count,
// then the ramp emits one step per cycle while the output register is free. No new
// sample is taken until the block is idle again.
// Configuration writes must happen while the block is idle.
`default_nettype none
`include "deadband_window_brightness_ramp_defines.svh"

module deadband_window_brightness_ramp
   import dbwbr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [LEVEL_BITS-1:0]          rsp_level,
   output logic                           rsp_last
);

   localparam int XW = SAMPLE_BITS + 8;

   state_type              state_ff, state_in;
   logic [7:0]             deadband_ff;
   logic [STEP_BITS-1:0]   ramp_steps_ff;
   logic [7:0]             window_low_ff;
   logic [7:0]             window_high_ff;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic [SAMPLE_BITS-1:0] lvl_ff, lvl_in;
   logic [STEP_BITS-1:0]   k_ff, k_in;
   logic                   up_ff, up_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]  rsp_level_ff, rsp_level_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_take;
   logic                   slot_free;
   logic [SAMPLE_BITS-1:0] samp_diff;
   logic                   pass_db;
   logic [XW-1:0]          tgt_x;
   logic                   in_window;
   logic                   go_ramp;
   logic                   up_now;
   logic [SAMPLE_BITS-1:0] lvl_diff;
   logic [STEP_BITS-1:0]   steps_eff;
   logic                   div_start;
   logic                   div_done;
   logic [SAMPLE_BITS-1:0] div_quo;
   logic [STEP_BITS-1:0]   div_rem;
   logic [XW-1:0]          rem_x;
   logic [SAMPLE_BITS-1:0] rem_s;
   logic [SAMPLE_BITS-1:0] step_lvl;
   logic [XW-1:0]          step_x;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DEADBAND_RST;
         ramp_steps_ff  <= RAMP_STEPS_RST;
         window_low_ff  <= WINDOW_LOW_RST;
         window_high_ff <= WINDOW_HIGH_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEADBAND:    deadband_ff    <= csr_wr_data[7:0];
            CSR_RAMP_STEPS:  ramp_steps_ff  <= csr_wr_data[STEP_BITS-1:0];
            CSR_WINDOW_LOW:  window_low_ff  <= csr_wr_data[7:0];
            CSR_WINDOW_HIGH: window_high_ff <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // deadband filter
   assign samp_diff = (held_ff >= req_sample) ? (held_ff - req_sample)
                                              : (req_sample - held_ff);
   assign pass_db   = (XW'(samp_diff) >= XW'(deadband_ff));

   // window and change check on the held value
   assign tgt_x     = XW'(held_ff);
   assign in_window = (tgt_x <= XW'(window_high_ff)) && (tgt_x >= XW'(window_low_ff));
   assign go_ramp   = in_window && (held_ff != cur_ff);
   assign up_now    = (held_ff > cur_ff);
   assign lvl_diff  = up_now ? (held_ff - cur_ff) : (cur_ff - held_ff);
   assign div_start = (state_ff == S_CHECK) && go_ramp;

   always_comb begin
      if (ramp_steps_ff == '0) begin
         steps_eff = MIN_STEPS;
      end else if (ramp_steps_ff > MAX_STEPS) begin
         steps_eff = MAX_STEPS;
      end else begin
         steps_eff = ramp_steps_ff;
      end
   end

   dbwbr_div #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lvl_diff),
      .divisor  (steps_eff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // remainder never exceeds the difference, so it fits the sample width
   assign rem_x    = XW'(div_rem);
   assign rem_s    = rem_x[SAMPLE_BITS-1:0];
   assign step_lvl = up_ff ? (lvl_ff + div_quo) : (lvl_ff - div_quo);
   assign step_x   = XW'(step_lvl);

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      k_in         = k_ff;
      up_in        = up_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (pass_db) begin
                  held_in = req_sample;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (go_ramp) begin
               up_in    = up_now;
               k_in     = steps_eff;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               lvl_in   = up_ff ? (cur_ff + rem_s) : (cur_ff - rem_s);
               state_in = S_RAMP;
            end
         end
         S_RAMP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = step_x[LEVEL_BITS-1:0];
               rsp_last_in  = (k_ff == STEP_BITS'(1));
               lvl_in       = step_lvl;
               k_in         = k_ff - STEP_BITS'(1);
               if (k_ff == STEP_BITS'(1)) begin
                  cur_in   = step_lvl;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      up_ff        <= up_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_last  = rsp_last_ff;

   `DBWBR_ASSERT_NEXT(a_ramp_lands_on_target, (state_ff == S_RAMP) && slot_free && (k_ff == STEP_BITS'(1)), (state_ff == S_IDLE) && (cur_ff == held_ff), "ramp did not end on the held value")
   `DBWBR_ASSERT_IMPL(a_div_done_in_div, div_done, state_ff == S_DIV, "divider finished outside the divide state")
   `DBWBR_ASSERT_IMPL(a_ramp_count_live, state_ff == S_RAMP, k_ff != '0, "ramp running with no steps left")
   `DBWBR_ASSERT_NEXT(a_take_goes_check, req_take, state_ff == S_CHECK, "accepted sample did not reach the check state")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the deadband window brightness ramp
// depends on dbwbr_pkg and the deadband_window_brightness_ramp top level
// predicts every ramp step at sample acceptance and checks results in order
`timescale 1ns / 100ps

module testbench;
   import dbwbr_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   // filter and check, serial divide, longest ramp, plus margin
   localparam int DRAIN_CYCLES = 2 + SAMPLE_BITS_DEF + 64 + 24;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 60;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  last;
   } ramp_step_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   csr_index_type                csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wr_data;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [SAMPLE_BITS_DEF-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]        rsp_level;
   logic                         rsp_last;

   // predictor copy of the registers and state
   logic [7:0]           deadband_w;
   logic [STEP_BITS-1:0] step_cfg;
   logic [7:0]           win_lo;
   logic [7:0]           win_hi;
   logic [7:0]           held_val;
   logic [7:0]           cur_level;

   logic [7:0]    sample_q[$];
   ramp_step_type level_q[$];
   int         pending_items = 0;
   int         errors        = 0;
   int         samples_sent  = 0;
   int         steps_seen    = 0;
   int         csr_writes    = 0;
   int         settings_run  = 0;
   int         cycles        = 0;
   bit         no_gaps       = 1'b0;
   logic [7:0] last_pushed   = '0;

   deadband_window_brightness_ramp dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_level   (rsp_level),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // deadband filter, window test and ramp split for one accepted sample
   task automatic predict_ramp(input logic [7:0] s);
      logic [7:0]           gap;
      logic [STEP_BITS-1:0] n;
      logic [7:0]           span;
      logic [7:0]           quot;
      logic [7:0]           rem;
      logic [7:0]           lvl;
      bit                   up;
      ramp_step_type        step;
      gap = (held_val >= s) ? held_val - s : s - held_val;
      if (gap >= deadband_w)
         held_val = s;
      if (held_val > win_hi || held_val < win_lo || held_val == cur_level)
         return;
      n = step_cfg;
      if (n == 0)
         n = MIN_STEPS;
      if (n > MAX_STEPS)
         n = MAX_STEPS;
      up   = held_val > cur_level;
      span = up ? held_val - cur_level : cur_level - held_val;
      quot = span / n;
      rem  = span % n;
      // remainder goes in first so the last step lands on the target
      lvl  = up ? cur_level + rem : cur_level - rem;
      for (int k = 0; k < n; k++) begin
         lvl = up ? lvl + quot : lvl - quot;
         step.level = lvl;
         step.last  = (k == n - 1);
         level_q.push_back(step);
      end
      cur_level = lvl;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DEADBAND:    deadband_w = val;
         CSR_RAMP_STEPS:  step_cfg   = val[STEP_BITS-1:0];
         CSR_WINDOW_LOW:  win_lo     = val;
         CSR_WINDOW_HIGH: win_hi     = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic send(input logic [7:0] s);
      sample_q.push_back(s);
      pending_items++;
      last_pushed = s;
   endtask

   // block is idle once all samples are taken and all ramp steps are back;
   // samples that give no ramp may still be in the pipe, hence the drain
   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_items != 0 || level_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      settings_run++;
   endtask

   task automatic random_config();
      write_csr(CSR_DEADBAND, 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(24)));
      write_csr(CSR_RAMP_STEPS, 8'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                            : $urandom_range(16, 1)));
      if ($urandom_range(7) == 0) begin
         write_csr(CSR_WINDOW_LOW, 8'($urandom_range(255)));
         write_csr(CSR_WINDOW_HIGH, 8'($urandom_range(255)));
      end else begin
         write_csr(CSR_WINDOW_LOW, 8'($urandom_range(40)));
         write_csr(CSR_WINDOW_HIGH, 8'($urandom_range(255, 200)));
      end
   endtask

   task automatic random_samples(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 6 || win_lo > win_hi)
            send(8'($urandom_range(255)));
         else if (pick < 8)
            send(8'($urandom_range(win_hi, win_lo)));
         else
            send(last_pushed + 8'($urandom_range(6)) - 8'd3);  // sensor jitter
      end
   endtask

   // sample driver: holds a stalled transaction, otherwise loads the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_ramp(req_sample);
            samples_sent++;
            pending_items--;
         end
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
               req_valid  <= 1'b1;
               req_sample <= sample_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ramp step monitor
   always @(posedge clock) begin
      ramp_step_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            steps_seen++;
            if (level_q.size() == 0) begin
               report($sformatf("unexpected step level=%0d last=%0b", rsp_level, rsp_last));
            end else begin
               want = level_q.pop_front();
               if (rsp_level !== want.level)
                  report($sformatf("level got %0d want %0d", rsp_level, want.level));
               if (rsp_last !== want.last)
                  report($sformatf("last got %0b want %0b", rsp_last, want.last));
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_DEADBAND;
      csr_wr_data = '0;
      deadband_w  = DEADBAND_RST;
      step_cfg    = RAMP_STEPS_RST;
      win_lo      = WINDOW_LOW_RST;
      win_hi      = WINDOW_HIGH_RST;
      held_val    = '0;
      cur_level   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no change, noise, above and below window, both edges
      send(8'd0);
      send(8'd4);
      send(8'd255);
      send(8'd240);
      send(8'd16);
      send(8'd20);
      send(8'd5);
      send(8'd130);
      wait_idle();

      // zero deadband, zero step count, full window
      write_csr(CSR_DEADBAND, 8'd0);
      write_csr(CSR_RAMP_STEPS, 8'd0);
      write_csr(CSR_WINDOW_LOW, 8'd0);
      write_csr(CSR_WINDOW_HIGH, 8'd255);
      send(8'd0);
      send(8'd255);
      send(8'haa);
      send(8'h55);
      send(8'd1);
      send(8'd254);
      send(8'd254);
      wait_idle();

      // longest ramp, including a one-count change spread over all steps
      write_csr(CSR_DEADBAND, 8'd1);
      write_csr(CSR_RAMP_STEPS, 8'd64);
      send(8'd3);
      send(8'd200);
      send(8'd201);
      send(8'd201);
      wait_idle();

      // widest deadband, step counts over the limit, inverted window
      write_csr(CSR_DEADBAND, 8'd255);
      write_csr(CSR_RAMP_STEPS, 8'd100);
      write_csr(CSR_RAMP_STEPS, 8'd200);
      write_csr(CSR_WINDOW_LOW, 8'd200);
      write_csr(CSR_WINDOW_HIGH, 8'd50);
      send(8'd0);
      send(8'd255);
      send(8'd100);
      wait_idle();
      write_csr(CSR_DEADBAND, 8'd0);
      send(8'd0);
      send(8'd255);
      send(8'd128);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config();
         no_gaps = (p == 2);
         random_samples(PHASE_ITEMS);
         wait_idle();
      end
      no_gaps = 1'b0;

      if (level_q.size() != 0)
         report($sformatf("%0d ramp steps never arrived", level_q.size()));
      $display("covered %0d samples under %0d register settings (%0d writes)",
               samples_sent, settings_run, csr_writes);
      $display("checked %0d ramp steps, %0d mismatches", steps_seen, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
